// ===== rtl/mns_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mns_pkg: shared types and constants for the melody note sequencer
// Item layouts, operation codes, note entry and note table access types.
// ----------------------------------------------------------------------------
package mns_pkg;

    // Default configuration
    localparam int NUM_SONGS_DEF      = 3;
    localparam int NOTES_PER_SONG_DEF = 256;
    localparam int REST_TONE_DEF      = 0;

    // Field widths
    localparam int OP_W      = 3;
    localparam int TICK_W    = 8;
    localparam int SONG_W    = 4;
    localparam int VOL_W     = 7;
    localparam int MS_W      = 16;
    localparam int IDX_W     = 8;
    localparam int TONE_W    = 8;
    localparam int ELAPSED_W = 17;
    localparam int GAP_W     = MS_W - 3;

    localparam logic [VOL_W-1:0] VOL_MAX      = 7'd100;
    localparam logic [VOL_W-1:0] BEEP_VOL_MIN = 7'd3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_PLAY_ONCE = 3'd1;
    localparam logic [OP_W-1:0] OP_PLAY_LOOP = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
    localparam logic [OP_W-1:0] OP_BEEP      = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE     = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TICK_W-1:0] elapsed_ms;
        logic [SONG_W-1:0] song_id;
        logic [VOL_W-1:0]  volume;
        logic [MS_W-1:0]   beep_ms;
        logic [IDX_W-1:0]  note_index;
        logic [TONE_W-1:0] note_tone;
        logic [MS_W-1:0]   note_ms;
    } req_t;

    typedef struct packed {
        logic              buzzer_on;
        logic              beep_tone;
        logic [TONE_W-1:0] tone_code;
        logic [VOL_W-1:0]  buzzer_volume;
        logic              playing;
        logic [SONG_W-1:0] current_song;
        logic [IDX_W-1:0]  note_position;
    } rsp_t;

    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic [MS_W-1:0]   ms;
    } note_entry_t;

    // Note table write command
    typedef struct packed {
        logic              en;
        logic [SONG_W-1:0] song;
        logic [IDX_W-1:0]  index;
        note_entry_t       entry;
    } note_wr_t;

    // Note table read request: port a at (song_a, index_a), port b at (song_b, 0)
    typedef struct packed {
        logic [SONG_W-1:0] song_a;
        logic [IDX_W-1:0]  index_a;
        logic [SONG_W-1:0] song_b;
    } note_rd_t;

endpackage : mns_pkg
`default_nettype wire

// ===== rtl/mns_note_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mns_note_store: note table with one write and two registered reads
// Port a follows the next note of the active song, port b a song's first
// note. A write to the address being read shows up on the read data.
// ----------------------------------------------------------------------------
module mns_note_store #(
    parameter int NUM_SONGS      = mns_pkg::NUM_SONGS_DEF,
    parameter int NOTES_PER_SONG = mns_pkg::NOTES_PER_SONG_DEF
) (
    input  wire                  clk,
    input  mns_pkg::note_wr_t    wr,
    input  mns_pkg::note_rd_t    rd,
    output mns_pkg::note_entry_t entry_a,
    output mns_pkg::note_entry_t entry_b
);

    localparam int DEPTH = NUM_SONGS * NOTES_PER_SONG;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic in_range(
        input logic [mns_pkg::SONG_W-1:0] song,
        input logic [mns_pkg::IDX_W-1:0]  idx
    );
        in_range = (song != '0) && (song <= mns_pkg::SONG_W'(NUM_SONGS)) &&
                   ({1'b0, idx} < (mns_pkg::IDX_W + 1)'(NOTES_PER_SONG));
    endfunction

    function automatic logic [AW-1:0] slot(
        input logic [mns_pkg::SONG_W-1:0] song,
        input logic [mns_pkg::IDX_W-1:0]  idx
    );
        slot = AW'((int'(song) - 1) * NOTES_PER_SONG + int'(idx));
    endfunction

    mns_pkg::note_entry_t mem [DEPTH];

    logic [AW-1:0]        wa;
    logic [AW-1:0]        ra;
    logic [AW-1:0]        rb;
    logic                 wr_ok;
    mns_pkg::note_entry_t rd_a_reg;
    mns_pkg::note_entry_t rd_b_reg;
    mns_pkg::note_entry_t wdata_reg;
    logic                 hit_a_reg;
    logic                 hit_b_reg;

    // Resolve addresses; out-of-range reads fall back to slot zero, out-of-range writes are dropped
    always_comb
    begin
        wr_ok = wr.en && in_range(wr.song, wr.index);
        wa    = slot(wr.song, wr.index);
        ra    = in_range(rd.song_a, rd.index_a) ? slot(rd.song_a, rd.index_a) : '0;
        rb    = in_range(rd.song_b, '0) ? slot(rd.song_b, '0) : '0;
    end

    // Write and read the table; remember write hits for forwarding
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wa] <= wr.entry;
        end
        rd_a_reg  <= mem[ra];
        rd_b_reg  <= mem[rb];
        wdata_reg <= wr.entry;
        hit_a_reg <= wr_ok && (wa == ra);
        hit_b_reg <= wr_ok && (wa == rb);
    end

    assign entry_a = hit_a_reg ? wdata_reg : rd_a_reg;
    assign entry_b = hit_b_reg ? wdata_reg : rd_b_reg;

endmodule : mns_note_store
`default_nettype wire

// ===== rtl/mns_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mns_core: sequencer state and per-item update
// Applies one command or tick to the song and beep state
// and forms the result from the updated state.
// ----------------------------------------------------------------------------
module mns_core #(
    parameter int NUM_SONGS      = mns_pkg::NUM_SONGS_DEF,
    parameter int NOTES_PER_SONG = mns_pkg::NOTES_PER_SONG_DEF,
    parameter int REST_TONE      = mns_pkg::REST_TONE_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               fire,
    input  mns_pkg::req_t                     item,
    input  mns_pkg::note_entry_t              entry_a,
    input  mns_pkg::note_entry_t              entry_b,
    input  wire                               cfg_we,
    input  wire        [mns_pkg::VOL_W-1:0]   cfg_wdata,
    output mns_pkg::rsp_t                     result,
    output logic       [mns_pkg::SONG_W-1:0]  song_next,
    output logic       [mns_pkg::IDX_W-1:0]   next_index
);

    typedef struct packed {
        logic [mns_pkg::SONG_W-1:0]    active_song;
        logic [mns_pkg::VOL_W-1:0]     song_volume;
        logic [mns_pkg::IDX_W-1:0]     note_pointer;
        logic [mns_pkg::MS_W-1:0]      phase_length;
        logic [mns_pkg::GAP_W-1:0]     gap_length;
        logic                          in_gap;
        logic                          song_active;
        logic                          loop_mode;
        logic [mns_pkg::ELAPSED_W-1:0] song_elapsed;
        logic                          beep_active;
        logic [mns_pkg::ELAPSED_W-1:0] beep_elapsed;
        logic [mns_pkg::MS_W-1:0]      beep_length;
        logic                          snd_on;
        logic                          snd_beep;
        logic [mns_pkg::TONE_W-1:0]    snd_tone;
        logic [mns_pkg::VOL_W-1:0]     snd_vol;
    } seq_state_t;

    localparam logic [mns_pkg::TONE_W-1:0] REST = mns_pkg::TONE_W'(REST_TONE);

    function automatic seq_state_t buzz_off(input seq_state_t s);
        seq_state_t r;
        r          = s;
        r.snd_on   = 1'b0;
        r.snd_beep = 1'b0;
        r.snd_tone = '0;
        r.snd_vol  = '0;
        return r;
    endfunction

    function automatic seq_state_t stop_all(input seq_state_t s);
        seq_state_t r;
        r              = buzz_off(s);
        r.beep_active  = 1'b0;
        r.song_active  = 1'b0;
        r.loop_mode    = 1'b0;
        r.active_song  = '0;
        r.note_pointer = '0;
        r.phase_length = '0;
        r.in_gap       = 1'b0;
        r.gap_length   = '0;
        return r;
    endfunction

    function automatic logic [mns_pkg::ELAPSED_W-1:0] sat_add(
        input logic [mns_pkg::ELAPSED_W-1:0] a,
        input logic [mns_pkg::TICK_W-1:0]    b
    );
        logic [mns_pkg::ELAPSED_W:0] s;
        s = {1'b0, a} + (mns_pkg::ELAPSED_W + 1)'(b);
        return s[mns_pkg::ELAPSED_W] ? '1 : s[mns_pkg::ELAPSED_W-1:0];
    endfunction

    // Load a note; an empty or missing note ends the song or wraps to note 0
    function automatic seq_state_t start_note(
        input seq_state_t                 s,
        input logic                       idx_ok,
        input logic [mns_pkg::IDX_W-1:0]  idx,
        input mns_pkg::note_entry_t       e,
        input mns_pkg::note_entry_t       e0
    );
        seq_state_t                 r;
        logic [mns_pkg::TONE_W-1:0] tone;
        logic [mns_pkg::MS_W-1:0]   ms;
        logic [mns_pkg::IDX_W-1:0]  pos;
        r    = s;
        tone = idx_ok ? e.tone : '0;
        ms   = idx_ok ? e.ms : '0;
        pos  = idx;
        if (ms == '0)
        begin
            if (!s.loop_mode)
            begin
                return stop_all(s);
            end
            pos  = '0;
            tone = e0.tone;
            ms   = e0.ms;
        end
        r.note_pointer = pos;
        if (tone == REST)
        begin
            r.gap_length   = '0;
            r.phase_length = ms;
        end
        else
        begin
            r.gap_length   = ms[mns_pkg::MS_W-1:3];
            r.phase_length = ms - {3'b000, ms[mns_pkg::MS_W-1:3]};
        end
        r.in_gap       = 1'b0;
        r.song_elapsed = '0;
        if (tone == REST)
        begin
            r = buzz_off(r);
        end
        else
        begin
            r.snd_on   = 1'b1;
            r.snd_beep = 1'b0;
            r.snd_tone = tone;
            r.snd_vol  = s.song_volume;
        end
        return r;
    endfunction

    seq_state_t                   st_reg;
    seq_state_t                   st_next;
    logic [mns_pkg::VOL_W-1:0]    beep_volume_reg;
    logic [mns_pkg::VOL_W-1:0]    beep_vol;
    logic [mns_pkg::ELAPSED_W-1:0] se;
    logic [mns_pkg::ELAPSED_W-1:0] be;
    logic [mns_pkg::IDX_W:0]      succ;
    logic                         succ_ok;
    logic                         song_ok;

    // Compute the state after the item in the input register
    always_comb
    begin
        st_next  = st_reg;
        se       = sat_add(st_reg.song_elapsed, item.elapsed_ms);
        be       = sat_add(st_reg.beep_elapsed, item.elapsed_ms);
        succ     = {1'b0, st_reg.note_pointer} + (mns_pkg::IDX_W + 1)'(1);
        succ_ok  = succ < (mns_pkg::IDX_W + 1)'(NOTES_PER_SONG);
        song_ok  = (item.song_id != '0) &&
                   (item.song_id <= mns_pkg::SONG_W'(NUM_SONGS)) &&
                   (item.volume != '0);
        beep_vol = beep_volume_reg;
        if (beep_vol < mns_pkg::BEEP_VOL_MIN)
        begin
            beep_vol = mns_pkg::BEEP_VOL_MIN;
        end
        if (beep_vol > mns_pkg::VOL_MAX)
        begin
            beep_vol = mns_pkg::VOL_MAX;
        end

        if (fire)
        begin
            unique case (item.operation)
                mns_pkg::OP_TICK:
                begin
                    st_next.song_elapsed = se;
                    st_next.beep_elapsed = be;
                    if (st_reg.beep_active)
                    begin
                        // Beep holds the song off until it runs out
                        if (be >= {1'b0, st_reg.beep_length})
                        begin
                            st_next.beep_active = 1'b0;
                            st_next = buzz_off(st_next);
                        end
                    end
                    else if (st_reg.song_active && (se >= {1'b0, st_reg.phase_length}))
                    begin
                        if (!st_reg.in_gap && (st_reg.gap_length != '0))
                        begin
                            // Enter the silent tail of the note
                            st_next.in_gap       = 1'b1;
                            st_next.phase_length = {3'b000, st_reg.gap_length};
                            st_next.song_elapsed = '0;
                            st_next = buzz_off(st_next);
                        end
                        else
                        begin
                            st_next.in_gap = 1'b0;
                            st_next = start_note(st_next, succ_ok,
                                                 succ[mns_pkg::IDX_W-1:0], entry_a, entry_b);
                        end
                    end
                end
                mns_pkg::OP_PLAY_ONCE, mns_pkg::OP_PLAY_LOOP:
                begin
                    if (item.operation == mns_pkg::OP_PLAY_ONCE)
                    begin
                        st_next.beep_active = 1'b0;
                    end
                    if (!song_ok)
                    begin
                        st_next = stop_all(st_next);
                    end
                    else
                    begin
                        st_next.active_song = item.song_id;
                        st_next.song_volume = (item.volume > mns_pkg::VOL_MAX) ?
                                              mns_pkg::VOL_MAX : item.volume;
                        st_next.loop_mode   = (item.operation == mns_pkg::OP_PLAY_LOOP);
                        st_next.song_active = 1'b1;
                        st_next.in_gap      = 1'b0;
                        st_next = start_note(st_next, 1'b1, '0, entry_b, entry_b);
                    end
                end
                mns_pkg::OP_STOP:
                begin
                    st_next = stop_all(st_reg);
                end
                mns_pkg::OP_BEEP:
                begin
                    if (!st_reg.song_active)
                    begin
                        st_next.snd_on       = 1'b1;
                        st_next.snd_beep     = 1'b1;
                        st_next.snd_tone     = '0;
                        st_next.snd_vol      = beep_vol;
                        st_next.beep_elapsed = '0;
                        st_next.beep_length  = item.beep_ms;
                        st_next.beep_active  = 1'b1;
                    end
                end
                default:
                begin
                    // Note writes go to the table only; unknown codes do nothing
                end
            endcase
        end
    end

    // Hold the sequencer state and the beep volume register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= '0;
            beep_volume_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                beep_volume_reg <= cfg_wdata;
            end
        end
    end

    // Form the result from the updated state
    always_comb
    begin
        result.buzzer_on     = st_next.snd_on;
        result.beep_tone     = st_next.snd_on && st_next.snd_beep;
        result.tone_code     = (st_next.snd_on && !st_next.snd_beep) ? st_next.snd_tone : '0;
        result.buzzer_volume = st_next.snd_on ? st_next.snd_vol : '0;
        result.playing       = st_next.song_active;
        result.current_song  = st_next.active_song;
        result.note_position = st_next.note_pointer;
    end

    // Point the table reads at the note after the upcoming pointer
    assign song_next  = st_next.active_song;
    assign next_index = st_next.note_pointer + mns_pkg::IDX_W'(1);

endmodule : mns_core
`default_nettype wire

// ===== rtl/melody_note_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// melody_note_sequencer: buzzer melody sequencer, top level
// Input register, sequencer core with note table, result register.
// ----------------------------------------------------------------------------
//  channel   signals                      direction  transfer when
//  req       req_valid, req_ready, req    in         req_valid && req_ready
//  rsp       rsp_valid, rsp_ready, rsp    out        rsp_valid && rsp_ready
//  cfg       cfg_we, cfg_wdata            in         cfg_we (beep volume)
//
//  One item per cycle sustained while rsp_ready stays high; each item gives
//  one result through the input register, then the result register.
//  The note table reads for an item are issued as it enters the input
//  register, so no note change holds up the request channel.
//  Reset clears all sequencer state; the note table is not cleared.
//  With rsp_ready low the result register holds, one more item is taken
//  into the input register, then req_ready drops.
// ----------------------------------------------------------------------------
module melody_note_sequencer #(
    parameter int NUM_SONGS      = mns_pkg::NUM_SONGS_DEF,
    parameter int NOTES_PER_SONG = mns_pkg::NOTES_PER_SONG_DEF,
    parameter int REST_TONE      = mns_pkg::REST_TONE_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              req_valid,
    output logic                             req_ready,
    input  mns_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  wire                              rsp_ready,
    output mns_pkg::rsp_t                    rsp,
    input  wire                              cfg_we,
    input  wire        [mns_pkg::VOL_W-1:0]  cfg_wdata
);

    mns_pkg::req_t               item_reg;
    mns_pkg::req_t               item_next;
    logic                        item_valid_reg;
    logic                        item_valid_next;
    logic                        rsp_valid_next;
    mns_pkg::rsp_t               rsp_reg;
    mns_pkg::rsp_t               result;
    logic                        accept;
    logic                        fire;
    logic [mns_pkg::SONG_W-1:0]  song_next;
    logic [mns_pkg::IDX_W-1:0]   next_index;
    mns_pkg::note_entry_t        entry_a;
    mns_pkg::note_entry_t        entry_b;
    mns_pkg::note_wr_t           note_wr;
    mns_pkg::note_rd_t           note_rd;

    // Handshake: advance the input register when the result register is free
    always_comb
    begin
        fire      = item_valid_reg && (!rsp_valid || rsp_ready);
        req_ready = !item_valid_reg || fire;
        accept    = req_valid && req_ready;
        item_next = accept ? req : item_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid;
        end
    end

    // Hold control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid      <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            rsp_valid      <= rsp_valid_next;
        end
    end

    // Capture the item and the result
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp = rsp_reg;

    // Table access: write on a note write transfer; port b serves a play
    // waiting in the input register, else the active song's first note
    always_comb
    begin
        note_wr.en          = fire && (item_reg.operation == mns_pkg::OP_WRITE);
        note_wr.song        = item_reg.song_id;
        note_wr.index       = item_reg.note_index;
        note_wr.entry.tone  = item_reg.note_tone;
        note_wr.entry.ms    = item_reg.note_ms;
        note_rd.song_a      = song_next;
        note_rd.index_a     = next_index;
        note_rd.song_b      = ((item_next.operation == mns_pkg::OP_PLAY_ONCE) ||
                               (item_next.operation == mns_pkg::OP_PLAY_LOOP)) ?
                              item_next.song_id : song_next;
    end

    mns_note_store #(
        .NUM_SONGS      (NUM_SONGS),
        .NOTES_PER_SONG (NOTES_PER_SONG)
    ) u_note_store (
        .clk     (clk),
        .wr      (note_wr),
        .rd      (note_rd),
        .entry_a (entry_a),
        .entry_b (entry_b)
    );

    mns_core #(
        .NUM_SONGS      (NUM_SONGS),
        .NOTES_PER_SONG (NOTES_PER_SONG),
        .REST_TONE      (REST_TONE)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .entry_a    (entry_a),
        .entry_b    (entry_b),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .result     (result),
        .song_next  (song_next),
        .next_index (next_index)
    );

endmodule : melody_note_sequencer
`default_nettype wire

// ===== tb/tb_melody_note_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_melody_note_sequencer: self-checking testbench for the melody sequencer
// Sends tick, play, stop, beep and note write commands on the request channel.
// A behavioral copy of the sequencer computes the sound state after every
// command, and each response is checked field by field against it. Both
// channels idle at random, and one long response stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb_melody_note_sequencer;

    import mns_pkg::*;

    localparam int SONGS     = NUM_SONGS_DEF;
    localparam int NOTES     = NOTES_PER_SONG_DEF;
    localparam int DEPTH     = SONGS * NOTES;
    localparam int TIME_SAT  = 131071;
    localparam logic [TONE_W-1:0] REST_CODE = TONE_W'(REST_TONE_DEF);

    // operation codes the block must ignore
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

    typedef enum {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;
    logic               cfg_we    = 1'b0;
    logic [VOL_W-1:0]   cfg_wdata = '0;

    // stimulus and scoreboard bookkeeping
    req_t     cmd_backlog[$];
    rsp_t     predicted_sound[$];
    rsp_t     want_sound;
    int       n_queued   = 0;
    int       n_accepted = 0;
    int       n_checked  = 0;
    int       n_errors   = 0;
    bit       req_went   = 1'b0;
    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_e rx_mode    = RX_ALWAYS;
    int       mode_left  = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;

    // note table as the stimulus side knows it, to keep plays on written notes
    int plan_ms      [DEPTH];
    bit plan_written [DEPTH];

    // sequencer state held by the predictor
    logic [TONE_W-1:0] tone_mem [DEPTH];
    logic [MS_W-1:0]   dur_mem  [DEPTH];
    logic [VOL_W-1:0]  beep_vol_setting = '0;
    int                cur_song    = 0;
    int                song_vol    = 0;
    int                note_ptr    = 0;
    int                phase_len   = 0;
    int                gap_len     = 0;
    int                song_ms     = 0;
    int                beep_ms_acc = 0;
    int                beep_len    = 0;
    bit                in_gap      = 1'b0;
    bit                song_on     = 1'b0;
    bit                looping     = 1'b0;
    bit                beep_on     = 1'b0;
    bit                snd_on      = 1'b0;
    bit                snd_beep    = 1'b0;
    int                snd_tone    = 0;
    int                snd_vol     = 0;

    melody_note_sequencer #(
        .NUM_SONGS      (SONGS),
        .NOTES_PER_SONG (NOTES),
        .REST_TONE      (REST_TONE_DEF)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------------
    function automatic int slot_of(input int s, input int idx);
        return (s - 1) * NOTES + idx;
    endfunction

    function automatic void silence();
        snd_on   = 1'b0;
        snd_beep = 1'b0;
        snd_tone = 0;
        snd_vol  = 0;
    endfunction

    function automatic void halt_all();
        silence();
        beep_on   = 1'b0;
        song_on   = 1'b0;
        looping   = 1'b0;
        cur_song  = 0;
        note_ptr  = 0;
        phase_len = 0;
        in_gap    = 1'b0;
        gap_len   = 0;
    endfunction

    // Load note idx; an index past the table or a zero length ends the song or, when looping, wraps to note 0
    function automatic void begin_note(input int idx);
        int tone;
        int ms;
        tone = 0;
        ms   = 0;
        if (idx < NOTES)
        begin
            tone = tone_mem[slot_of(cur_song, idx)];
            ms   = dur_mem[slot_of(cur_song, idx)];
        end
        if (ms == 0)
        begin
            if (!looping)
            begin
                halt_all();
                return;
            end
            idx  = 0;
            tone = tone_mem[slot_of(cur_song, 0)];
            ms   = dur_mem[slot_of(cur_song, 0)];
        end
        note_ptr = idx;
        if (tone == REST_CODE)
        begin
            gap_len   = 0;
            phase_len = ms;
        end
        else
        begin
            gap_len   = ms / 8;
            phase_len = ms - gap_len;
        end
        in_gap  = 1'b0;
        song_ms = 0;
        if (tone == REST_CODE)
            silence();
        else
        begin
            snd_on   = 1'b1;
            snd_beep = 1'b0;
            snd_tone = tone;
            snd_vol  = song_vol;
        end
    endfunction

    function automatic void begin_song(input int id, input int vol, input bit repeat_song);
        if (id < 1 || id > SONGS || vol == 0)
        begin
            halt_all();
            return;
        end
        cur_song = id;
        song_vol = (vol > VOL_MAX) ? VOL_MAX : vol;
        looping  = repeat_song;
        song_on  = 1'b1;
        in_gap   = 1'b0;
        begin_note(0);
    endfunction

    function automatic int sat_sum(input int a, input int b);
        return (a + b > TIME_SAT) ? TIME_SAT : a + b;
    endfunction

    // Advance time; a running beep holds the song logic off
    function automatic void advance_time(input int ms);
        song_ms     = sat_sum(song_ms, ms);
        beep_ms_acc = sat_sum(beep_ms_acc, ms);
        if (beep_on)
        begin
            if (beep_ms_acc >= beep_len)
            begin
                beep_on = 1'b0;
                silence();
            end
            return;
        end
        if (!song_on || song_ms < phase_len)
            return;
        if (!in_gap && gap_len != 0)
        begin
            in_gap    = 1'b1;
            phase_len = gap_len;
            song_ms   = 0;
            silence();
            return;
        end
        in_gap = 1'b0;
        begin_note(note_ptr + 1);
    endfunction

    function automatic void start_beep(input int ms);
        int v;
        v = beep_vol_setting;
        if (song_on)
            return;
        if (v < BEEP_VOL_MIN)
            v = BEEP_VOL_MIN;
        if (v > VOL_MAX)
            v = VOL_MAX;
        snd_on      = 1'b1;
        snd_beep    = 1'b1;
        snd_tone    = 0;
        snd_vol     = v;
        beep_ms_acc = 0;
        beep_len    = ms;
        beep_on     = 1'b1;
    endfunction

    // Apply one command and return the sound state that follows it
    function automatic rsp_t step_sequencer(input req_t item);
        rsp_t sound;
        case (item.operation)
            OP_TICK:      advance_time(item.elapsed_ms);
            OP_PLAY_ONCE:
            begin
                beep_on = 1'b0;
                begin_song(item.song_id, item.volume, 1'b0);
            end
            OP_PLAY_LOOP: begin_song(item.song_id, item.volume, 1'b1);
            OP_STOP:      halt_all();
            OP_BEEP:      start_beep(item.beep_ms);
            OP_WRITE:
            begin
                if (item.song_id >= 1 && item.song_id <= SONGS && item.note_index < NOTES)
                begin
                    tone_mem[slot_of(item.song_id, item.note_index)] = item.note_tone;
                    dur_mem[slot_of(item.song_id, item.note_index)]  = item.note_ms;
                end
            end
            default: ;
        endcase
        sound.buzzer_on     = snd_on;
        sound.beep_tone     = snd_on && snd_beep;
        sound.tone_code     = (snd_on && !snd_beep) ? TONE_W'(snd_tone) : '0;
        sound.buzzer_volume = snd_on ? VOL_W'(snd_vol) : '0;
        sound.playing       = song_on;
        sound.current_song  = SONG_W'(cur_song);
        sound.note_position = IDX_W'(note_ptr);
        return sound;
    endfunction

    // ------------------------------------------------------------------------
    // Command generation
    // ------------------------------------------------------------------------

    // A song may be played once every note it can reach is written. Note 0
    // never counts as the end, since a looped song steps past an empty note 0.
    function automatic bit song_playable(input int s);
        for (int i = 0; i < NOTES; i++)
        begin
            if (!plan_written[slot_of(s, i)])
                return 1'b0;
            if (i >= 1 && plan_ms[slot_of(s, i)] == 0)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic push_item(input req_t item);
        int s;
        int k;
        bit was_ok;
        s = item.song_id;
        // redirect a play of a song that is not fully written to song 0 (stop)
        if ((item.operation == OP_PLAY_ONCE || item.operation == OP_PLAY_LOOP) &&
            s >= 1 && s <= SONGS && !song_playable(s))
            item.song_id = '0;
        if (item.operation == OP_WRITE && s >= 1 && s <= SONGS && item.note_index < NOTES)
        begin
            k               = slot_of(s, item.note_index);
            was_ok          = song_playable(s);
            plan_ms[k]      = item.note_ms;
            plan_written[k] = 1'b1;
            // end the song at this note rather than let it run into unwritten ones
            if (was_ok && !song_playable(s))
            begin
                item.note_ms = '0;
                plan_ms[k]   = 0;
            end
        end
        cmd_backlog.push_back(item);
        n_queued++;
    endtask

    function automatic req_t random_item(input logic [OP_W-1:0] op);
        logic [95:0] bits;
        req_t        item;
        bits           = {$urandom, $urandom, $urandom};
        item           = bits[$bits(req_t)-1:0];
        item.operation = op;
        return item;
    endfunction

    function automatic logic [TONE_W-1:0] random_tone();
        return ($urandom_range(0, 3) == 0) ? REST_CODE : TONE_W'($urandom_range(1, 255));
    endfunction

    task automatic send_tick(input int ms);
        req_t it;
        it            = random_item(OP_TICK);
        it.elapsed_ms = ms;
        push_item(it);
    endtask

    task automatic send_play(input logic [OP_W-1:0] op, input int s, input int vol);
        req_t it;
        it         = random_item(op);
        it.song_id = s;
        it.volume  = vol;
        push_item(it);
    endtask

    task automatic send_beep(input int ms);
        req_t it;
        it         = random_item(OP_BEEP);
        it.beep_ms = ms;
        push_item(it);
    endtask

    task automatic send_stop();
        push_item(random_item(OP_STOP));
    endtask

    task automatic send_write(input int s, input int idx, input logic [TONE_W-1:0] tone,
                              input int ms);
        req_t it;
        it            = random_item(OP_WRITE);
        it.song_id    = s;
        it.note_index = idx;
        it.note_tone  = tone;
        it.note_ms    = ms;
        push_item(it);
    endtask

    // Mostly ticks, with beeps, stops, stray writes, plays and unused codes
    task automatic run_activity(input int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
                send_tick($urandom_range(0, 255));
            else if (r < 83)
                send_beep(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 400));
            else if (r < 86)
                send_stop();
            else if (r < 91)
                push_item(random_item(OP_WRITE));
            else if (r < 94)
                push_item(random_item(($urandom_range(0, 1) == 0) ? OP_RSVD_A : OP_RSVD_B));
            else
                push_item(random_item(($urandom_range(0, 1) == 0) ? OP_PLAY_ONCE
                                                                   : OP_PLAY_LOOP));
        end
    endtask

    // Write the beep volume once every command so far has its response
    task automatic set_beep_volume(input int v);
        wait (n_checked == n_queued);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we           <= 1'b1;
        cfg_wdata        <= VOL_W'(v);
        beep_vol_setting  = VOL_W'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_went))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (cmd_backlog.size() != 0)
            begin
                req       <= cmd_backlog.pop_front();
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                req_valid <= 1'b0;
        end
        req_went = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Response ready: switch among stall patterns, hold off once for long
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   = rx_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end
        else
            mode_left--;
        if (!hold_done && n_accepted >= 600)
        begin
            hold_done = 1'b1;
            hold_left = 120;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS: rsp_ready <= 1'b1;
                RX_HALF:   rsp_ready <= ($urandom_range(0, 1) == 0);
                RX_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
                default:   rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Predict on each request transfer, check each response transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            predicted_sound.push_back(step_sequencer(req));
            n_accepted++;
            req_went = 1'b1;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (predicted_sound.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
                n_errors++;
            end
            else
            begin
                want_sound = predicted_sound.pop_front();
                n_checked++;
                check_field("buzzer_on", want_sound.buzzer_on, rsp.buzzer_on);
                check_field("beep_tone", want_sound.beep_tone, rsp.beep_tone);
                check_field("tone_code", want_sound.tone_code, rsp.tone_code);
                check_field("buzzer_volume", want_sound.buzzer_volume, rsp.buzzer_volume);
                check_field("playing", want_sound.playing, rsp.playing);
                check_field("current_song", want_sound.current_song, rsp.current_song);
                check_field("note_position", want_sound.note_position, rsp.note_position);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int vol_plan [4] = '{3, 100, 2, 126};
        int ph;
        int first;
        int s;
        int r;
        int n;
        int i;
        int len;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: beep volume 0 is raised to the minimum
        set_beep_volume(0);
        send_tick(0);
        send_beep(0);
        send_tick(255);
        // invalid song numbers act as stop
        send_play(OP_PLAY_ONCE, 0, 50);
        send_play(OP_PLAY_LOOP, 5, 50);
        // writes to invalid songs are dropped
        send_write(0, 0, 8'h11, 100);
        send_write(15, 3, 8'h22, 100);
        // song 1: tone with a gap, a rest, then the end marker
        send_write(1, 2, 8'h80, 0);
        send_write(1, 1, REST_CODE, 5);
        send_write(1, 0, 8'hFF, 16);
        send_play(OP_PLAY_ONCE, 1, 127);
        send_tick(14);
        send_tick(2);
        send_tick(5);
        // looped play keeps a pending beep; its expiry silences the note
        send_beep(20);
        send_play(OP_PLAY_LOOP, 1, 1);
        send_tick(255);
        send_tick(255);
        send_beep(10);
        send_play(OP_PLAY_ONCE, 1, 100);
        send_stop();
        send_beep(65535);
        send_tick(255);
        send_stop();
        send_play(OP_PLAY_LOOP, 1, 0);
        push_item(random_item(OP_RSVD_A));
        push_item(random_item(OP_RSVD_B));
        // song 2: looped song with an empty note 0
        send_write(2, 1, 8'h09, 0);
        send_write(2, 0, 8'h05, 0);
        send_play(OP_PLAY_LOOP, 2, 60);
        send_tick(0);
        send_tick(3);
        send_stop();

        // fill every note of song 3, run it looped past the end, then once
        set_beep_volume(127);
        for (i = NOTES - 1; i >= 0; i--)
            send_write(3, i, random_tone(), $urandom_range(1, 9));
        send_beep(500);
        send_play(OP_PLAY_LOOP, 3, 90);
        repeat (340) send_tick($urandom_range(1, 255));
        send_play(OP_PLAY_ONCE, 3, 100);
        repeat (340) send_tick($urandom_range(1, 255));

        // random phases, each under its own beep volume
        for (ph = 0; ph < 5; ph++)
        begin
            set_beep_volume((ph == 4) ? $urandom_range(0, 127) : vol_plan[ph]);
            first = n_queued;
            while (n_queued - first < 210)
            begin
                s = $urandom_range(1, SONGS);
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    // mostly compose a short song back to front, then play it or another song number
                    if ($urandom_range(0, 2) != 0)
                    begin
                        n = $urandom_range(1, 10);
                        send_write(s, n, random_tone(), 0);
                        for (i = n - 1; i >= 0; i--)
                        begin
                            r = $urandom_range(0, 19);
                            if (r == 0)
                                len = 0;
                            else if (r == 1)
                                len = $urandom_range(2000, 65535);
                            else
                                len = $urandom_range(1, 600);
                            send_write(s, i, random_tone(), len);
                        end
                    end
                    send_play(($urandom_range(0, 1) == 0) ? OP_PLAY_ONCE : OP_PLAY_LOOP,
                              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : s,
                              ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127));
                    run_activity($urandom_range(5, 40));
                end
                else if (r < 8)
                begin
                    send_beep($urandom_range(0, 600));
                    if ($urandom_range(0, 1) == 0)
                        send_play(OP_PLAY_LOOP, s, $urandom_range(1, 127));
                    run_activity($urandom_range(5, 15));
                end
                else if (r == 8)
                    repeat ($urandom_range(3, 10))
                        push_item(random_item(OP_W'($urandom_range(0, 7))));
                else
                    run_activity($urandom_range(5, 20));
            end
        end

        // drain, then let the pipeline settle
        wait (n_checked == n_queued);
        repeat (10) @(posedge clk);
        if (n_errors == 0 && predicted_sound.size() == 0)
            $display("melody_note_sequencer regression: pass");
        else
            $display("melody_note_sequencer regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("melody_note_sequencer regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mns_pkg.sv
rtl/mns_note_store.sv
rtl/mns_core.sv
rtl/melody_note_sequencer.sv
tb/tb_melody_note_sequencer.sv
